// ===== rtl/core/qtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtm_pkg
// Shared constants for the quaternion TRS matrix builder: the fixed scale
// format used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package qtm_pkg;

  // Scale is signed Q8.8 regardless of the coordinate and quaternion widths.
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;

endpackage

// ===== rtl/core/qtm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtm_in_if
// Request channel: position, rotation quaternion and per-axis scale,
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qtm_in_if import qtm_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int QUAT_WIDTH  = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [QUAT_WIDTH-1:0]  quat_w;
  logic signed [QUAT_WIDTH-1:0]  quat_x;
  logic signed [QUAT_WIDTH-1:0]  quat_y;
  logic signed [QUAT_WIDTH-1:0]  quat_z;
  logic signed [SCALE_W-1:0]     scale_x;
  logic signed [SCALE_W-1:0]     scale_y;
  logic signed [SCALE_W-1:0]     scale_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
           scale_x, scale_y, scale_z,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
           scale_x, scale_y, scale_z,
    output ready
  );
endinterface

// ===== rtl/core/qtm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtm_out_if
// Result channel: nine rotation-times-scale entries and the translation
// column, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qtm_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] m00;
  logic signed [COORD_WIDTH-1:0] m01;
  logic signed [COORD_WIDTH-1:0] m02;
  logic signed [COORD_WIDTH-1:0] m10;
  logic signed [COORD_WIDTH-1:0] m11;
  logic signed [COORD_WIDTH-1:0] m12;
  logic signed [COORD_WIDTH-1:0] m20;
  logic signed [COORD_WIDTH-1:0] m21;
  logic signed [COORD_WIDTH-1:0] m22;
  logic signed [COORD_WIDTH-1:0] t_x;
  logic signed [COORD_WIDTH-1:0] t_y;
  logic signed [COORD_WIDTH-1:0] t_z;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z,
    input  ready
  );

  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z,
    output ready
  );
endinterface

// ===== rtl/core/quaternion_trs_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_trs_matrix
// Builds the model matrix M = T*R*S from position, unit quaternion and
// per-axis scale, as a four-stage fixed-point pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per transform (pos Q16.16, quat Q2.14, scale Q8.8
//             at the default widths), taken when valid and ready are high.
//   out_rsp : one result per request, in order: the 3x3 rotation-times-scale
//             entries (column j scaled by scale j, saturated) and the
//             translation column, which is the position passed through.
//             The bottom row 0,0,0,1 is implied and not carried.
//   Stages  : of the four, stage 1 registers the nine quaternion products,
//             stage 2 the rotation entries rounded or shifted to RF fraction
//             bits, stage 3 the nine scaled entries, and stage 4 the final
//             rounding with saturation in the output register, whose valid
//             drives out_rsp.valid.
//   Throughput: one request per cycle unless out_rsp stalls.
//   Stall   : when out_rsp.ready is low the last stage holds its result;
//             earlier stages keep advancing into empty slots, so up to four
//             requests are held in flight and none is lost or repeated.
//   Reset   : rst_n low (synchronous) empties every stage; in_req.ready is
//             high right after reset.
// ----------------------------------------------------------------------------
module quaternion_trs_matrix import qtm_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qtm_in_if.sink    in_req,
  qtm_out_if.source out_rsp
);

  // Fixed-point formats
  localparam int CF    = COORD_WIDTH / 2;          // result fraction bits
  localparam int QF    = QUAT_WIDTH - 2;           // quaternion fraction bits
  localparam int PF    = 2 * QF;                   // product fraction bits
  localparam int RF    = CF + SCALE_FRAC;          // rotation entry fraction bits
  localparam int PW    = 2 * QUAT_WIDTH;           // quaternion product width
  localparam int EW    = 2 * QUAT_WIDTH + 3;       // exact rotation entry width
  localparam int SH_L  = (RF > PF) ? RF - PF : 0;
  localparam int SH_R  = (PF > RF) ? PF - RF : 0;
  localparam int RW    = EW + SH_L;                // entry width at RF
  localparam int PRW   = RW + SCALE_W;             // entry times scale
  localparam int RDW   = PRW + 1 - 2 * SCALE_FRAC; // after final rounding
  localparam int XW    = ((RDW > COORD_WIDTH) ? RDW : COORD_WIDTH) + 1;
  localparam int NENT  = 9;

  localparam logic signed [EW-1:0] ONE_E = EW'(longint'(1) << PF);
  localparam logic signed [PRW:0]  HALF_P = (PRW+1)'(longint'(1) << (2 * SCALE_FRAC - 1));
  localparam logic signed [XW-1:0] MAX_X =
    XW'((longint'(1) << (COORD_WIDTH - 1)) - longint'(1));
  localparam logic signed [XW-1:0] MIN_X = -MAX_X - XW'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SCALE_W-1:0]     scale_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [EW-1:0]          ent_t;
  typedef logic signed [RW-1:0]          rent_t;
  typedef logic signed [PRW-1:0]         sprod_t;

  // ------------------------------------------------------------------------
  // Stall control: a stage moves when it is empty or its successor moves.
  // ------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_rsp.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_req.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_req.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // Translation travels alongside, untouched.
  coord_t tx1_r, ty1_r, tz1_r, tx2_r, ty2_r, tz2_r;
  coord_t tx3_r, ty3_r, tz3_r, tx4_r, ty4_r, tz4_r;
  scale_t sx1_r, sy1_r, sz1_r, sx2_r, sy2_r, sz2_r;

  // ------------------------------------------------------------------------
  // Stage 1: the nine quaternion products, exact.
  // ------------------------------------------------------------------------
  prod_t p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_xz_r, p_yz_r, p_wx_r, p_wy_r, p_wz_r;

  always_ff @(posedge clk) begin
    if (adv1 && in_req.valid) begin
      p_xx_r <= PW'(in_req.quat_x) * PW'(in_req.quat_x);
      p_yy_r <= PW'(in_req.quat_y) * PW'(in_req.quat_y);
      p_zz_r <= PW'(in_req.quat_z) * PW'(in_req.quat_z);
      p_xy_r <= PW'(in_req.quat_x) * PW'(in_req.quat_y);
      p_xz_r <= PW'(in_req.quat_x) * PW'(in_req.quat_z);
      p_yz_r <= PW'(in_req.quat_y) * PW'(in_req.quat_z);
      p_wx_r <= PW'(in_req.quat_w) * PW'(in_req.quat_x);
      p_wy_r <= PW'(in_req.quat_w) * PW'(in_req.quat_y);
      p_wz_r <= PW'(in_req.quat_w) * PW'(in_req.quat_z);
      sx1_r  <= in_req.scale_x;
      sy1_r  <= in_req.scale_y;
      sz1_r  <= in_req.scale_z;
      tx1_r  <= in_req.pos_x;
      ty1_r  <= in_req.pos_y;
      tz1_r  <= in_req.pos_z;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 2: rotation entries, then move them to RF fraction bits.
  // ------------------------------------------------------------------------
  ent_t  ent   [NENT];
  rent_t rent  [NENT];
  rent_t r2_r  [NENT];

  always_comb begin
    ent[0] = ONE_E - ((EW'(p_yy_r) + EW'(p_zz_r)) <<< 1);
    ent[1] = (EW'(p_xy_r) + EW'(p_wz_r)) <<< 1;
    ent[2] = (EW'(p_xz_r) - EW'(p_wy_r)) <<< 1;
    ent[3] = (EW'(p_xy_r) - EW'(p_wz_r)) <<< 1;
    ent[4] = ONE_E - ((EW'(p_xx_r) + EW'(p_zz_r)) <<< 1);
    ent[5] = (EW'(p_yz_r) + EW'(p_wx_r)) <<< 1;
    ent[6] = (EW'(p_xz_r) + EW'(p_wy_r)) <<< 1;
    ent[7] = (EW'(p_yz_r) - EW'(p_wx_r)) <<< 1;
    ent[8] = ONE_E - ((EW'(p_xx_r) + EW'(p_yy_r)) <<< 1);
  end

  generate
    if (SH_R > 0) begin : g_round_down
      localparam logic signed [EW:0] HALF_R = (EW+1)'(longint'(1) << (SH_R - 1));
      logic signed [EW:0] biased [NENT];
      always_comb begin
        for (int i = 0; i < NENT; i++) begin
          // round half up: add half, then floor
          biased[i] = (EW+1)'(ent[i]) + HALF_R;
          rent[i]   = RW'(biased[i] >>> SH_R);
        end
      end
    end else begin : g_shift_up
      always_comb begin
        for (int i = 0; i < NENT; i++) begin
          rent[i] = RW'(ent[i]) <<< SH_L;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      r2_r  <= rent;
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      sz2_r <= sz1_r;
      tx2_r <= tx1_r;
      ty2_r <= ty1_r;
      tz2_r <= tz1_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 3: scale each column by its axis scale.
  // ------------------------------------------------------------------------
  sprod_t s3_r [NENT];

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      for (int i = 0; i < NENT; i++) begin
        if (i < 3)      s3_r[i] <= PRW'(r2_r[i]) * PRW'(sx2_r);
        else if (i < 6) s3_r[i] <= PRW'(r2_r[i]) * PRW'(sy2_r);
        else            s3_r[i] <= PRW'(r2_r[i]) * PRW'(sz2_r);
      end
      tx3_r <= tx2_r;
      ty3_r <= ty2_r;
      tz3_r <= tz2_r;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 4: round half up to CF fraction bits, saturate, hold for output.
  // ------------------------------------------------------------------------
  logic signed [PRW:0]   rnd  [NENT];
  logic signed [XW-1:0]  ext  [NENT];
  coord_t                sat  [NENT];
  coord_t                m4_r [NENT];

  always_comb begin
    for (int i = 0; i < NENT; i++) begin
      rnd[i] = (PRW+1)'(s3_r[i]) + HALF_P;
      ext[i] = XW'(rnd[i] >>> (2 * SCALE_FRAC));
      if (ext[i] > MAX_X)      sat[i] = COORD_WIDTH'(MAX_X);
      else if (ext[i] < MIN_X) sat[i] = COORD_WIDTH'(MIN_X);
      else                     sat[i] = COORD_WIDTH'(ext[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      m4_r  <= sat;
      tx4_r <= tx3_r;
      ty4_r <= ty3_r;
      tz4_r <= tz3_r;
    end
  end

  // Drive the response channel from the output register.
  assign out_rsp.valid = v4_r;
  assign out_rsp.m00   = m4_r[0];
  assign out_rsp.m01   = m4_r[1];
  assign out_rsp.m02   = m4_r[2];
  assign out_rsp.m10   = m4_r[3];
  assign out_rsp.m11   = m4_r[4];
  assign out_rsp.m12   = m4_r[5];
  assign out_rsp.m20   = m4_r[6];
  assign out_rsp.m21   = m4_r[7];
  assign out_rsp.m22   = m4_r[8];
  assign out_rsp.t_x   = tx4_r;
  assign out_rsp.t_y   = ty4_r;
  assign out_rsp.t_z   = tz4_r;

`ifndef SYNTH
  // An empty first stage must always take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_req.ready)
    else $error("in_req.ready low with stage 1 empty");

  // Reset empties the whole pipe.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r && !v4_r))
    else $error("pipeline not empty after reset");

  // A blocked middle stage keeps its request.
  a_hold_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !adv3) |=> v2_r)
    else $error("stage 2 request dropped while stalled");

  // A result blocked at the output keeps its x translation and its m00 entry.
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_rsp.ready) |=> (v4_r && $stable(tx4_r) && $stable(m4_r[0])))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sv/qtm_trs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtm_trs_checker
// Watches the request and result channels of the TRS matrix builder. Each
// accepted request is turned into the expected saturated matrix and the
// expected translation. Each accepted result is compared with the oldest
// expected matrix, field by field. Mismatches are counted and handed out.
// ----------------------------------------------------------------------------
module qtm_trs_checker import qtm_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst_n,
  qtm_in_if    in_ch,
  qtm_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);

  localparam int     CF     = COORD_WIDTH / 2;
  localparam int     QF     = QUAT_WIDTH - 2;
  localparam int     PF     = 2 * QF;
  localparam int     RF     = CF + SCALE_FRAC;
  localparam longint SAT_HI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Index 0..8 are m00..m22, 9..11 the translation column.
  typedef logic [11:0][COORD_WIDTH-1:0] matrix_t;

  matrix_t matrix_q[$];
  int      errs         = 0;
  int      results_seen = 0;
  string   field_name [12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                               "m20", "m21", "m22", "t_x", "t_y", "t_z"};

  function automatic longint round_half_up(longint v, int n);
    if (n <= 0) return v;
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Rotation entry with 2*QF fraction bits, times a Q8.8 scale.
  function automatic logic [COORD_WIDTH-1:0] scaled_entry(longint r, longint s);
    longint rf;
    longint p;
    if (PF > RF) rf = round_half_up(r, PF - RF);
    else         rf = r <<< (RF - PF);
    p = round_half_up(rf * s, 2 * SCALE_FRAC);
    if (p > SAT_HI)      p = SAT_HI;
    else if (p < SAT_LO) p = SAT_LO;
    return p[COORD_WIDTH-1:0];
  endfunction

  function automatic matrix_t model_matrix();
    matrix_t m;
    longint  one, w, x, y, z, sx, sy, sz;
    longint  xx, yy, zz, xy, xz, yz, wx, wy, wz;
    one = longint'(1) <<< PF;
    w  = in_ch.quat_w;
    x  = in_ch.quat_x;
    y  = in_ch.quat_y;
    z  = in_ch.quat_z;
    sx = in_ch.scale_x;
    sy = in_ch.scale_y;
    sz = in_ch.scale_z;
    xx = x * x;  yy = y * y;  zz = z * z;
    xy = x * y;  xz = x * z;  yz = y * z;
    wx = w * x;  wy = w * y;  wz = w * z;
    m[0]  = scaled_entry(one - 2 * (yy + zz), sx);
    m[1]  = scaled_entry(2 * (xy + wz), sx);
    m[2]  = scaled_entry(2 * (xz - wy), sx);
    m[3]  = scaled_entry(2 * (xy - wz), sy);
    m[4]  = scaled_entry(one - 2 * (xx + zz), sy);
    m[5]  = scaled_entry(2 * (yz + wx), sy);
    m[6]  = scaled_entry(2 * (xz + wy), sz);
    m[7]  = scaled_entry(2 * (yz - wx), sz);
    m[8]  = scaled_entry(one - 2 * (xx + yy), sz);
    m[9]  = in_ch.pos_x;
    m[10] = in_ch.pos_y;
    m[11] = in_ch.pos_z;
    return m;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errs++;
  endtask

  always @(posedge clk) begin
    matrix_t got;
    matrix_t want;
    if (!rst_n) begin
      matrix_q.delete();
    end else begin
      // Compare first so a request taken at this edge never pairs with it.
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.t_z, out_ch.t_y, out_ch.t_x,
               out_ch.m22, out_ch.m21, out_ch.m20,
               out_ch.m12, out_ch.m11, out_ch.m10,
               out_ch.m02, out_ch.m01, out_ch.m00};
        results_seen++;
        if (matrix_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
        end else begin
          want = matrix_q.pop_front();
          for (int k = 0; k < 12; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                        results_seen, field_name[k],
                                        $signed(got[k]), $signed(want[k])));
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) matrix_q.push_back(model_matrix());
    end
    fail_count    <= errs;
    pending       <= matrix_q.size();
    checked_count <= results_seen;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the TRS matrix builder. Sends a directed set of
// transforms, then random ones under four idle/stall mixes and one long
// output hold; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench import qtm_pkg::*;;

  localparam int CW = 32;
  localparam int QW = 16;

  // One in Q2.14 and cos(45 deg) in the same format.
  localparam int ONE_Q   = 1 << (QW - 2);
  localparam int COS45_Q = int'(real'(ONE_Q) * 0.7071067811865476);
  localparam int ONE_S   = 1 << SCALE_FRAC;

  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] POS_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam int Q_MAX = (1 << (QW - 1)) - 1;
  localparam int Q_MIN = -(1 << (QW - 1));
  localparam int S_MAX = (1 << (SCALE_W - 1)) - 1;
  localparam int S_MIN = -(1 << (SCALE_W - 1));

  localparam int AXIS_VALS   [5] = '{0, ONE_Q, -ONE_Q, COS45_Q, -COS45_Q};
  localparam int SCALE_EDGES [5] = '{0, ONE_S, -ONE_S, 32767, -32768};

  localparam int RANDOM_PER_PHASE = 85;
  localparam int PRESSURE_ITEMS   = 40;
  localparam int HOLD_CYCLES      = 150;
  localparam int DRAIN_CYCLES     = 16;
  localparam int LIMIT_CYCLES     = 200000;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int SEND_IDLE [4] = '{0, 70, 0, 37};
  localparam int RECV_IDLE [4] = '{0, 0, 70, 37};

  typedef struct packed {
    logic [2:0][CW-1:0]      pos;    // x y z
    logic [3:0][QW-1:0]      quat;   // w x y z
    logic [2:0][SCALE_W-1:0] scale;  // x y z
  } xform_t;

  logic clk = 1'b0;
  logic rst_n;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_done   = 0;
  int sent_count  = 0;
  int directed_n  = 0;
  int fail_count;
  int pending;
  int checked_count;

  qtm_in_if  #(.COORD_WIDTH(CW), .QUAT_WIDTH(QW)) in_req ();
  qtm_out_if #(.COORD_WIDTH(CW))                  out_rsp ();

  quaternion_trs_matrix #(.COORD_WIDTH(CW), .QUAT_WIDTH(QW)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  qtm_trs_checker #(.COORD_WIDTH(CW), .QUAT_WIDTH(QW)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_req),
    .out_ch        (out_rsp),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic xform_t make_xform(
    input logic [CW-1:0] px, py, pz,
    input int            qw, qx, qy, qz,
    input int            sx, sy, sz
  );
    xform_t t;
    t.pos   = {pz, py, px};
    t.quat  = {QW'(qz), QW'(qy), QW'(qx), QW'(qw)};
    t.scale = {SCALE_W'(sz), SCALE_W'(sy), SCALE_W'(sx)};
    return t;
  endfunction

  // Mostly unit quaternions with everyday scales; the rest are raw bit
  // patterns and axis-aligned turns so every field bit toggles.
  function automatic xform_t random_xform();
    xform_t t;
    real    comp [4];
    real    norm;
    int     pick;
    for (int k = 0; k < 3; k++) t.pos[k] = CW'({$urandom(), $urandom()});
    pick = $urandom_range(99);
    if (pick < 55) begin
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
        comp[k] = real'(int'($urandom_range(2000)) - 1000);
        norm += comp[k] * comp[k];
      end
      norm = $sqrt(norm);
      if (norm < 1.0) begin
        comp[0] = 1.0;
        norm    = 1.0;
      end
      for (int k = 0; k < 4; k++) t.quat[k] = QW'(int'(comp[k] / norm * real'(ONE_Q)));
    end else if (pick < 80) begin
      for (int k = 0; k < 4; k++) t.quat[k] = QW'($urandom());
    end else begin
      for (int k = 0; k < 4; k++) t.quat[k] = QW'(AXIS_VALS[$urandom_range(4)]);
    end
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(99);
      if (pick < 60)      t.scale[k] = SCALE_W'($urandom_range(2047) - 1024);
      else if (pick < 85) t.scale[k] = SCALE_W'($urandom());
      else                t.scale[k] = SCALE_W'(SCALE_EDGES[$urandom_range(4)]);
    end
    return t;
  endfunction

  // Offer one request and hold it until the block takes it. Idle cycles go
  // in front, so valid stays high back to back when no gap is drawn.
  task automatic drive_request(input xform_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.pos_x   <= t.pos[0];
    in_req.pos_y   <= t.pos[1];
    in_req.pos_z   <= t.pos[2];
    in_req.quat_w  <= t.quat[0];
    in_req.quat_x  <= t.quat[1];
    in_req.quat_y  <= t.quat[2];
    in_req.quat_z  <= t.quat[3];
    in_req.scale_x <= t.scale[0];
    in_req.scale_y <= t.scale[1];
    in_req.scale_z <= t.scale[2];
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    sent_count++;
  endtask

  // Result side: random stalls at the current rate, and a long hold
  // whenever the stimulus asks for one, counted here in cycles.
  initial begin : result_side
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    xform_t directed_q[$];

    rst_n          <= 1'b0;
    in_req.valid   <= 1'b0;
    in_req.pos_x   <= '0;
    in_req.pos_y   <= '0;
    in_req.pos_z   <= '0;
    in_req.quat_w  <= '0;
    in_req.quat_x  <= '0;
    in_req.quat_y  <= '0;
    in_req.quat_z  <= '0;
    in_req.scale_x <= '0;
    in_req.scale_y <= '0;
    in_req.scale_z <= '0;

    // Identity at unit scale, then all zero, all max and all min.
    directed_q.push_back(make_xform(0, 0, 0, ONE_Q, 0, 0, 0, ONE_S, ONE_S, ONE_S));
    directed_q.push_back(make_xform(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_xform(POS_MAX, POS_MAX, POS_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    S_MAX, S_MAX, S_MAX));
    directed_q.push_back(make_xform(POS_MIN, POS_MIN, POS_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    S_MIN, S_MIN, S_MIN));
    // Negated identity quaternion describes the same rotation.
    directed_q.push_back(make_xform(-1, 1, -1, -ONE_Q, 0, 0, 0, ONE_S, ONE_S, ONE_S));
    // Quarter turns about each axis.
    directed_q.push_back(make_xform(1, 2, 3, COS45_Q, COS45_Q, 0, 0, ONE_S, 2 * ONE_S,
                                    -3 * ONE_S));
    directed_q.push_back(make_xform(4, 5, 6, COS45_Q, 0, COS45_Q, 0, -ONE_S, ONE_S,
                                    ONE_S / 2));
    directed_q.push_back(make_xform(7, 8, 9, COS45_Q, 0, 0, -COS45_Q, 3, ONE_S, 100));
    // Half turns about each axis.
    directed_q.push_back(make_xform(POS_MAX, 0, POS_MIN, 0, ONE_Q, 0, 0, ONE_S, ONE_S,
                                    ONE_S));
    directed_q.push_back(make_xform(0, POS_MIN, 0, 0, 0, ONE_Q, 0, S_MAX, S_MIN, 1));
    directed_q.push_back(make_xform(0, 0, POS_MAX, 0, 0, 0, -ONE_Q, -1, 2, S_MAX));
    // Tiny products that land exactly on a rounding half, both signs.
    directed_q.push_back(make_xform(0, 0, 0, 2, 2, 2, 0, ONE_S, S_MIN, S_MAX));
    directed_q.push_back(make_xform(0, 0, 0, 0, 2, 2, 0, S_MIN, 128, 1));
    directed_q.push_back(make_xform(0, 0, 0, 0, -2, 2, 0, 128, S_MIN, -128));
    // Zero scale kills the rotation.
    directed_q.push_back(make_xform(5, -5, 5, COS45_Q, COS45_Q, 0, 0, 0, 0, 0));
    // Far from unit length with alternating signs.
    directed_q.push_back(make_xform(1, POS_MIN, POS_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                    S_MIN, S_MAX, -1));
    directed_q.push_back(make_xform(-2, -3, -4, Q_MIN, Q_MAX, Q_MIN, Q_MAX, S_MAX, S_MAX,
                                    S_MAX));
    // Half-valued unit quaternion and the smallest nonzero components.
    directed_q.push_back(make_xform(100, 200, 300, ONE_Q / 2, ONE_Q / 2, ONE_Q / 2,
                                    ONE_Q / 2, 3 * ONE_S, 128, 64));
    directed_q.push_back(make_xform(0, 0, 0, -1, -1, -1, -1, S_MAX, S_MAX, S_MAX));
    directed_q.push_back(make_xform(0, 0, 0, 0, 0, 0, ONE_Q, -ONE_S, -ONE_S, -ONE_S));
    directed_n = directed_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Four idle/stall mixes; the first one has no idling and carries the
    // directed set.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = SEND_IDLE[phase];
      stall_pct = RECV_IDLE[phase];
      if (phase == 0) begin
        foreach (directed_q[k]) drive_request(directed_q[k]);
      end
      repeat (RANDOM_PER_PHASE) drive_request(random_xform());
    end

    // Hold the result side off while requests keep coming, so the pipeline
    // fills and backs up into the request channel.
    idle_pct  = 0;
    stall_pct = 0;
    hold_asked++;
    repeat (PRESSURE_ITEMS) drive_request(random_xform());

    in_req.valid <= 1'b0;
    @(posedge clk);

    // Drain: wait for every expected result, then a few cycles more to
    // catch anything extra.
    stall_pct = 20;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d directed) over four idle/stall mixes and a %0d-cycle",
             sent_count, directed_n, HOLD_CYCLES);
    $display("output hold; %0d results compared field by field, %0d mismatches.",
             checked_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2);
    $display("Timeout after %0d cycles, %0d results still outstanding", LIMIT_CYCLES,
             pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
